// ----- rtl/parallel_bus_handshake_master_defines.svh -----
// Assertion macros used by the parallel bus master top level.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef PARALLEL_BUS_HANDSHAKE_MASTER_DEFINES_SVH
`define PARALLEL_BUS_HANDSHAKE_MASTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PBHM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pbhm assertion failed");

// Next-cycle implication, checked out of reset.
`define PBHM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pbhm assertion failed");

`endif

// ----- rtl/pbhm_pkg.sv -----
// Types and constants for the parallel bus handshake master.
// No dependencies; used by the sequencer and the top level.
`timescale 1ns / 1ps

package pbhm_pkg;

  localparam int unsigned TimeoutWidth = 16;
  localparam logic [TimeoutWidth-1:0] TimeoutReset = 16'd25000;

  // Operation codes on func
  localparam logic [1:0] OpRead  = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpBlock = 2'd2;

  // Completion status codes
  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatNoAck = 2'd1;
  localparam logic [1:0] StatStuck = 2'd2;

  typedef struct packed {
    logic       start_req;
    logic [1:0] func;
    logic [1:0] slave;
    logic [7:0] write_data;
    logic       ack_in;
    logic [7:0] bus_in;
  } in_item_t;

  typedef struct packed {
    logic [3:0] req_lines;
    logic       rw_level;
    logic       drive_enable;
    logic [7:0] drive_data;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] block_length;
    logic       busy_res;
  } out_item_t;

  typedef logic [TimeoutWidth-1:0] timeout_t;

endpackage

// ----- rtl/pbhm_stream_if.sv -----
// Valid/ready channel carrying one payload per transaction.
// Payload type is set per instance; typically a struct from pbhm_pkg.
`timescale 1ns / 1ps

interface pbhm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/pbhm_seq.sv -----
// Handshake sequencer: phase, timeout counter and per-operation state.
// Depends on pbhm_pkg; advances one sample per accepted transaction.
`timescale 1ns / 1ps

module pbhm_seq #(
  parameter int unsigned SLAVE_COUNT = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  pbhm_pkg::in_item_t   item_i,
  input  pbhm_pkg::timeout_t   timeout_i,
  output pbhm_pkg::out_item_t  result_o
);

  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhWaitHi = 2'd1;
  localparam logic [1:0] PhWaitLo = 2'd2;

  localparam logic [2:0] SlaveLimit = 3'(SLAVE_COUNT);

  logic [1:0]         phase_q, phase_d;
  pbhm_pkg::timeout_t wait_q, wait_d;
  logic [1:0]         op_q, op_d;
  logic [1:0]         slave_q, slave_d;
  logic [7:0]         wbyte_q, wbyte_d;
  logic [7:0]         left_q, left_d;
  logic               len_seen_q, len_seen_d;
  logic [7:0]         cap_q, cap_d;

  logic       hi;
  logic       drive;
  logic [7:0] left_next;

  always_comb begin
    phase_d    = phase_q;
    wait_d     = wait_q;
    op_d       = op_q;
    slave_d    = slave_q;
    wbyte_d    = wbyte_q;
    left_d     = left_q;
    len_seen_d = len_seen_q;
    cap_d      = cap_q;
    left_next  = left_q;

    result_o = '0;

    case (phase_q)
      PhIdle: begin
        if (item_i.start_req && (item_i.func <= pbhm_pkg::OpBlock)) begin
          op_d       = item_i.func;
          slave_d    = item_i.slave;
          wbyte_d    = item_i.write_data;
          len_seen_d = 1'b0;
          left_d     = '0;
          wait_d     = '0;
          phase_d    = PhWaitHi;
        end
      end
      PhWaitHi: begin
        if (item_i.ack_in) begin
          if (op_q != pbhm_pkg::OpWrite) begin
            cap_d = item_i.bus_in;
          end
          wait_d  = '0;
          phase_d = PhWaitLo;
        end else if (wait_q == timeout_i) begin
          phase_d           = PhIdle;
          result_o.done_res = 1'b1;
          result_o.status   = pbhm_pkg::StatNoAck;
        end else begin
          wait_d = wait_q + 1'b1;
        end
      end
      PhWaitLo: begin
        if (!item_i.ack_in) begin
          wait_d = '0;
          if (op_q == pbhm_pkg::OpBlock) begin
            if (!len_seen_q) begin
              // first handshake of a block read carries the length
              len_seen_d            = 1'b1;
              left_next             = cap_q;
              result_o.block_length = cap_q;
            end else begin
              result_o.data_valid = 1'b1;
              result_o.data_byte  = cap_q;
              left_next           = left_q - 1'b1;
            end
            left_d = left_next;
            if (left_next == '0) begin
              phase_d           = PhIdle;
              result_o.done_res = 1'b1;
            end else begin
              phase_d = PhWaitHi;
            end
          end else begin
            if (op_q == pbhm_pkg::OpRead) begin
              result_o.data_valid = 1'b1;
              result_o.data_byte  = cap_q;
            end
            phase_d           = PhIdle;
            result_o.done_res = 1'b1;
          end
        end else if (wait_q == timeout_i) begin
          phase_d           = PhIdle;
          result_o.done_res = 1'b1;
          result_o.status   = pbhm_pkg::StatStuck;
        end else begin
          wait_d = wait_q + 1'b1;
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase

    // Bus levels follow the state after this sample
    hi    = (phase_d == PhWaitHi);
    drive = hi && (op_d == pbhm_pkg::OpWrite);
    if (hi && ({1'b0, slave_d} < SlaveLimit)) begin
      result_o.req_lines = 4'b0001 << slave_d;
    end
    result_o.rw_level     = (op_d == pbhm_pkg::OpWrite);
    result_o.drive_enable = drive;
    result_o.drive_data   = drive ? wbyte_d : 8'd0;
    result_o.busy_res     = (phase_d != PhIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      wait_q     <= '0;
      op_q       <= pbhm_pkg::OpRead;
      slave_q    <= '0;
      wbyte_q    <= '0;
      left_q     <= '0;
      len_seen_q <= 1'b0;
      cap_q      <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      wait_q     <= wait_d;
      op_q       <= op_d;
      slave_q    <= slave_d;
      wbyte_q    <= wbyte_d;
      left_q     <= left_d;
      len_seen_q <= len_seen_d;
      cap_q      <= cap_d;
    end
  end

endmodule

// ----- rtl/parallel_bus_handshake_master.sv -----
// Top level of the parallel bus handshake master.
// Depends on pbhm_pkg, pbhm_stream_if, pbhm_seq and the defines header.
`timescale 1ns / 1ps
// Usage
//   in_i   : one transaction per pin sample tick: start_req/func/slave/write_data
//            to launch an operation, ack_in/bus_in as the sampled pin levels.
//   out_o  : exactly one result per input transaction, giving the request,
//            direction and drive levels after that sample, plus read data,
//            block length, done/status and busy.
//   cfg_i  : writes timeout_limit; always ready. Write only while idle.
// The result of a sample is registered and appears on out_o in the cycle after
// the input transaction is taken. Throughput: one transaction per cycle while
// out_o is ready; sequencer state and result register update once per sample.
// Stall: while out_o holds an untaken result, in_i.ready follows out_o.ready,
// so a new sample is taken in the same cycle the held result leaves.
// Reset: phase goes idle, sequencer state clears, timeout_limit returns to 25000,
// and no result is pending.

`include "parallel_bus_handshake_master_defines.svh"

module parallel_bus_handshake_master #(
  parameter int unsigned SLAVE_COUNT = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  pbhm_stream_if.sink    in_i,
  pbhm_stream_if.source  out_o,
  pbhm_stream_if.sink    cfg_i
);

  pbhm_pkg::timeout_t  timeout_q;
  pbhm_pkg::out_item_t result;
  pbhm_pkg::out_item_t out_q;
  logic                out_valid_q;
  logic                in_take;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_take     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  pbhm_seq #(
    .SLAVE_COUNT(SLAVE_COUNT)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_take),
    .item_i   (in_i.data),
    .timeout_i(timeout_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= pbhm_pkg::TimeoutReset;
    end else if (cfg_i.valid) begin
      timeout_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_take) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload register: load on every taken sample
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      out_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  `PBHM_ASSERT_NOW(a_req_onehot, out_valid_q, $onehot0(out_q.req_lines))
  `PBHM_ASSERT_NOW(a_status_needs_done, out_valid_q && (out_q.status != pbhm_pkg::StatOk),
                   out_q.done_res && !out_q.busy_res)
  `PBHM_ASSERT_NOW(a_read_data_dir, out_valid_q && out_q.data_valid,
                   !out_q.rw_level && !out_q.drive_enable)
  `PBHM_ASSERT_NEXT(a_take_loads_result, in_take, out_valid_q)

endmodule
